// ===== rtl/core/blrs_pkg.sv =====
// Package for the binary line run segmenter: sizes, limits and shared types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package blrs_pkg;

  localparam int LINE_MAX    = 1024;
  localparam int SEGMENT_MAX = 64;

  localparam int PIXEL_W = 8;
  localparam int POS_W   = $clog2(LINE_MAX) + 1;
  localparam int COORD_W = $clog2(LINE_MAX);
  localparam int WIDTH_W = $clog2(LINE_MAX) + 1;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(16);

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [WIDTH_W-1:0] seg_width_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic       segment_valid;
    coord_t     seg_start;
    coord_t     seg_end;
    seg_width_t seg_width;
    coord_t     seg_center;
    count_t     found_count;
    logic       line_done;
  } seg_result_t;

endpackage : blrs_pkg

`default_nettype wire

// ===== rtl/core/blrs_pixel_if.sv =====
// Pixel channel: one thresholded pixel per beat with an end-of-line flag.
// Depends on blrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface blrs_pixel_if
  import blrs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;
  logic               last_pixel;

  modport source (output valid, output pixel_value, output last_pixel, input ready);
  modport sink   (input valid, input pixel_value, input last_pixel, output ready);
endinterface : blrs_pixel_if

`default_nettype wire

// ===== rtl/core/blrs_segment_if.sv =====
// Segment channel: one segment report or end-of-line summary per beat.
// Depends on blrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface blrs_segment_if
  import blrs_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic       segment_valid;
  coord_t     seg_start;
  coord_t     seg_end;
  seg_width_t seg_width;
  coord_t     seg_center;
  count_t     found_count;
  logic       line_done;

  modport source (
    output valid, output segment_valid, output seg_start, output seg_end,
    output seg_width, output seg_center, output found_count, output line_done,
    input ready
  );
  modport sink (
    input valid, input segment_valid, input seg_start, input seg_end,
    input seg_width, input seg_center, input found_count, input line_done,
    output ready
  );
endinterface : blrs_segment_if

`default_nettype wire

// ===== rtl/core/binary_line_run_segmenter_unit.sv =====
// Top level of the binary line run segmenter: input register, run tracking and
// result register. Depends on blrs_pkg, blrs_pixel_if and blrs_segment_if.
//
//   channel   direction  beat
//   in_pix    sink       pixel_value, last_pixel
//   out_seg   source     segment report or line summary (at most one per pixel)
//   cfg_*     write      segment_limit, 7 bits
//
// A pixel waits in the input register and its result, if any, is registered into the
// output register as the pixel leaves; one pixel is taken per cycle unless the output stalls.
// The run state is updated as the pixel leaves the input register.
// Reset is synchronous and active low; the segment limit returns to 16.
// A stalled output holds its beat; the input register still drains pixels that
// produce no result, so only a result meeting a full output register stalls.
`timescale 1ns / 1ps
`default_nettype none

module binary_line_run_segmenter_unit
  import blrs_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [COUNT_W-1:0] cfg_wdata,
  blrs_pixel_if.sink          in_pix,
  blrs_segment_if.source      out_seg
);

  count_t      limit_r;
  logic        s1_valid_r;
  logic        s1_lit_r;
  logic        s1_last_r;
  pos_t        position_r;
  pos_t        position_nxt;
  logic        run_open_r;
  logic        run_open_nxt;
  coord_t      run_begin_r;
  coord_t      run_begin_nxt;
  count_t      found_r;
  count_t      found_nxt;
  logic        out_valid_r;
  seg_result_t res_r;
  seg_result_t res_nxt;

  count_t  lim_eff;
  logic    found_ok;
  logic    run_eff;
  logic    in_line;
  coord_t  pos_c;
  logic    emit;
  coord_t  seg_s;
  coord_t  seg_e;
  logic    open_a;
  coord_t  begin_a;
  pos_t    pos_a;
  count_t  found_a;
  logic    has_result;
  logic    out_free;
  logic    s1_adv;

  assign lim_eff  = (limit_r > COUNT_W'(SEGMENT_MAX)) ? COUNT_W'(SEGMENT_MAX) : limit_r;
  assign found_ok = found_r < lim_eff;
  assign run_eff  = run_open_r && found_ok;
  assign in_line  = position_r < POS_W'(LINE_MAX);
  assign pos_c    = position_r[COORD_W-1:0];

  always_comb begin
    emit    = 1'b0;
    seg_s   = run_begin_r;
    seg_e   = pos_c;
    open_a  = run_eff;
    begin_a = run_begin_r;
    pos_a   = position_r;
    if (in_line) begin
      pos_a = position_r + POS_W'(1);
      if (found_ok) begin
        if (s1_lit_r && !run_eff) begin
          open_a  = 1'b1;
          begin_a = pos_c;
        end else if (!s1_lit_r && run_eff) begin
          emit   = 1'b1;
          seg_s  = run_begin_r;
          seg_e  = pos_c - COORD_W'(1);
          open_a = 1'b0;
        end
        if (s1_last_r && open_a) begin
          emit   = 1'b1;
          seg_s  = begin_a;
          seg_e  = pos_c;
          open_a = 1'b0;
        end
      end
    end else if (s1_last_r && run_eff) begin
      emit   = 1'b1;
      seg_s  = run_begin_r;
      seg_e  = COORD_W'(LINE_MAX - 1);
      open_a = 1'b0;
    end
    found_a = found_r + COUNT_W'(emit);
  end

  always_comb begin
    if (s1_last_r) begin
      position_nxt  = '0;
      run_open_nxt  = 1'b0;
      run_begin_nxt = '0;
      found_nxt     = '0;
    end else begin
      position_nxt  = pos_a;
      run_open_nxt  = open_a;
      run_begin_nxt = begin_a;
      found_nxt     = found_a;
    end
  end

  always_comb begin
    res_nxt               = '0;
    res_nxt.segment_valid = emit;
    res_nxt.found_count   = found_a;
    res_nxt.line_done     = s1_last_r;
    if (emit) begin
      res_nxt.seg_start  = seg_s;
      res_nxt.seg_end    = seg_e;
      res_nxt.seg_width  = {1'b0, seg_e} - {1'b0, seg_s} + WIDTH_W'(1);
      res_nxt.seg_center = COORD_W'(({1'b0, seg_s} + {1'b0, seg_e}) >> 1);
    end
  end

  assign has_result = emit || s1_last_r;
  assign out_free   = !out_valid_r || out_seg.ready;
  assign s1_adv     = s1_valid_r && (!has_result || out_free);
  assign in_pix.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      s1_valid_r  <= 1'b0;
      position_r  <= '0;
      run_open_r  <= 1'b0;
      run_begin_r <= '0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (in_pix.ready) begin
        s1_valid_r <= in_pix.valid;
      end
      if (s1_adv) begin
        position_r  <= position_nxt;
        run_open_r  <= run_open_nxt;
        run_begin_r <= run_begin_nxt;
        found_r     <= found_nxt;
      end
      if (s1_adv && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_seg.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.ready && in_pix.valid) begin
      s1_lit_r  <= |in_pix.pixel_value;
      s1_last_r <= in_pix.last_pixel;
    end
    if (s1_adv && has_result) begin
      res_r <= res_nxt;
    end
  end

  assign out_seg.valid         = out_valid_r;
  assign out_seg.segment_valid = res_r.segment_valid;
  assign out_seg.seg_start     = res_r.seg_start;
  assign out_seg.seg_end       = res_r.seg_end;
  assign out_seg.seg_width     = res_r.seg_width;
  assign out_seg.seg_center    = res_r.seg_center;
  assign out_seg.found_count   = res_r.found_count;
  assign out_seg.line_done     = res_r.line_done;

  // The segment count never passes SEGMENT_MAX, the cap on any configured limit.
  a_found_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= COUNT_W'(SEGMENT_MAX))
    else $error("segment count above its maximum");

  // The position saturates at the line length.
  a_position_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= POS_W'(LINE_MAX))
    else $error("position beyond the line length");

  // Finishing the last pixel of a line leaves the line state cleared.
  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (position_r == '0 && !run_open_r && found_r == '0))
    else $error("line state not cleared after the last pixel");

  // A reported segment always counts itself.
  a_segment_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.segment_valid) |-> (res_r.found_count != '0))
    else $error("segment reported with a zero count");

endmodule : binary_line_run_segmenter_unit

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for binary_line_run_segmenter_unit: sends scan lines and compares every
// segment beat with a behavioural prediction. Depends on blrs_pkg, blrs_pixel_if
// and blrs_segment_if from the RTL.
`timescale 1ns / 1ps

module tb_top
  import blrs_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   cfg_we    = 1'b0;
  count_t cfg_wdata = '0;

  blrs_pixel_if   pix_if ();
  blrs_segment_if seg_if ();

  binary_line_run_segmenter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_if.sink),
    .out_seg   (seg_if.source)
  );

  always #4 clk = ~clk;

  seg_result_t expected_segments[$];
  int error_count   = 0;
  int stalled_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;

  // Predicted line state and segment limit.
  int   line_pos;
  int   run_first;
  int   seg_total;
  int   seg_limit;
  logic run_active;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
    error_count++;
  endtask

  task automatic predict_segment_result(input logic [PIXEL_W-1:0] pv, input logic lp);
    logic        lit;
    logic        emit;
    int          lim;
    int          s;
    int          e;
    seg_result_t r;
    lit  = (pv != '0);
    lim  = (seg_limit > SEGMENT_MAX) ? SEGMENT_MAX : seg_limit;
    emit = 1'b0;
    s    = 0;
    e    = 0;
    if (seg_total >= lim) run_active = 1'b0;
    if (line_pos < LINE_MAX) begin
      if (seg_total < lim) begin
        if (lit && !run_active) begin
          run_first  = line_pos;
          run_active = 1'b1;
        end else if (!lit && run_active) begin
          s = run_first;
          e = line_pos - 1;
          emit = 1'b1;
          seg_total++;
          run_active = 1'b0;
        end
        if (lp && run_active) begin
          s = run_first;
          e = line_pos;
          emit = 1'b1;
          seg_total++;
          run_active = 1'b0;
        end
      end
      line_pos++;
    end else if (lp && run_active && seg_total < lim) begin
      s = run_first;
      e = LINE_MAX - 1;
      emit = 1'b1;
      seg_total++;
      run_active = 1'b0;
    end
    r = '0;
    if (emit) begin
      r.segment_valid = 1'b1;
      r.seg_start     = coord_t'(s);
      r.seg_end       = coord_t'(e);
      r.seg_width     = seg_width_t'(e - s + 1);
      r.seg_center    = coord_t'((s + e) / 2);
    end
    r.found_count = count_t'(seg_total);
    if (lp) begin
      r.line_done = 1'b1;
      line_pos    = 0;
      run_active  = 1'b0;
      run_first   = 0;
      seg_total   = 0;
    end
    if (emit || lp) expected_segments.push_back(r);
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] pv, input logic lp);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= pv;
    pix_if.last_pixel  <= lp;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    predict_segment_result(pv, lp);
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (expected_segments.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= count_t'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    seg_limit = value;
  endtask

  task automatic send_random_line(input int len, input int density);
    logic [PIXEL_W-1:0] pv;
    for (int i = 0; i < len; i++) begin
      pv = ($urandom_range(99) < density) ? PIXEL_W'($urandom_range(1, 255)) : '0;
      send_pixel(pv, i == len - 1);
    end
  endtask

  task automatic send_alternating_line(input int len);
    for (int i = 0; i < len; i++) send_pixel((i % 2 == 0) ? 8'hFF : 8'h00, i == len - 1);
  endtask

  task automatic test_directed_pixels();
    send_idle_pct = 19;
    recv_idle_pct = 76;
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h02, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h40, 1'b0);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h7F, 1'b0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h01, 1'b1);
    send_pixel(8'h10, 1'b0);
    send_pixel(8'h20, 1'b0);
    send_pixel(8'h04, 1'b0);
    send_pixel(8'h08, 1'b1);
  endtask

  task automatic test_segment_limits();
    wait_idle();
    write_limit(0);
    send_alternating_line(5);
    wait_idle();
    write_limit(1);
    send_alternating_line(5);
    wait_idle();
    write_limit(127);
    send_alternating_line(140);
    wait_idle();
    write_limit(64);
    send_alternating_line(131);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b0);
    wait_idle();
    // Lowering the limit with a run open drops that run.
    write_limit(1);
    send_pixel(8'hFF, 1'b1);
    wait_idle();
    write_limit(2);
    send_alternating_line(7);
    wait_idle();
    write_limit(16);
  endtask

  task automatic test_position_limit();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 1030; i++) send_pixel((i >= 1000) ? 8'hC3 : 8'h00, i == 1029);
  endtask

  task automatic test_random_lines(input int items, input int sidle, input int ridle);
    int sent;
    int len;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        wait_idle();
        write_limit(($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12));
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 140) : $urandom_range(1, 32);
      send_random_line(len, $urandom_range(10, 90));
      sent += len;
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 300;
    for (int n = 0; n < 2; n++) send_alternating_line(30);
    wait_idle();
  endtask

  initial begin
    seg_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        seg_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        seg_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    seg_result_t want;
    if (rst_n && seg_if.valid && seg_if.ready) begin
      if (expected_segments.size() == 0) begin
        report_mismatch("unexpected segment beat", 1, 0);
      end else begin
        want = expected_segments.pop_front();
        if (seg_if.segment_valid !== want.segment_valid)
          report_mismatch("segment_valid", seg_if.segment_valid, want.segment_valid);
        if (seg_if.seg_start !== want.seg_start)
          report_mismatch("seg_start", seg_if.seg_start, want.seg_start);
        if (seg_if.seg_end !== want.seg_end)
          report_mismatch("seg_end", seg_if.seg_end, want.seg_end);
        if (seg_if.seg_width !== want.seg_width)
          report_mismatch("seg_width", seg_if.seg_width, want.seg_width);
        if (seg_if.seg_center !== want.seg_center)
          report_mismatch("seg_center", seg_if.seg_center, want.seg_center);
        if (seg_if.found_count !== want.found_count)
          report_mismatch("found_count", seg_if.found_count, want.found_count);
        if (seg_if.line_done !== want.line_done)
          report_mismatch("line_done", seg_if.line_done, want.line_done);
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_if.valid && pix_if.ready) || (seg_if.valid && seg_if.ready)) begin
      stalled_count = 0;
    end else begin
      stalled_count++;
    end
    if (stalled_count >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    pix_if.valid       = 1'b0;
    pix_if.pixel_value = '0;
    pix_if.last_pixel  = 1'b0;
    line_pos   = 0;
    run_first  = 0;
    seg_total  = 0;
    run_active = 1'b0;
    seg_limit  = int'(LIMIT_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_pixels();
    test_segment_limits();
    test_random_lines(40, 19, 76);
    test_random_lines(40, 76, 19);
    test_position_limit();
    test_random_lines(40, 0, 0);
    test_output_stall();
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule : tb_top
